// ===== src/bclp_pkg.sv =====
// Shared types and constants for the button click / long-press detector.
// No dependencies.
`timescale 1ns / 1ps

package bclp_pkg;

	// Widths of the channel fields
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int CLICK_W = 8;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ACTIVE_LEVEL    = 2'd0,
		REG_DEBOUNCE_TIME   = 2'd1,
		REG_LONG_PRESS_TIME = 2'd2,
		REG_CLICK_TIMEOUT   = 2'd3
	} cfg_reg_t;

	// Reported events
	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_LONG   = 3'd1,
		EV_SINGLE = 3'd2,
		EV_DOUBLE = 3'd3,
		EV_TRIPLE = 3'd4
	} event_t;

	// Reset values and write minimums of the timing registers
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd10;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] CLICK_TO_RST   = 16'd300;
	localparam logic [CFG_W-1:0] DEBOUNCE_MIN   = 16'd2;
	localparam logic [CFG_W-1:0] LONG_PRESS_MIN = 16'd100;
	localparam logic [CFG_W-1:0] CLICK_TO_MIN   = 16'd100;

	localparam logic [CLICK_W-1:0] CLICKS_MAX = 8'd255;

	// Configuration write, as seen by the core
	typedef struct packed {
		logic             en;
		cfg_reg_t         idx;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	// Raise a written value to its minimum
	function automatic logic [CFG_W-1:0] at_least(input logic [CFG_W-1:0] v,
			input logic [CFG_W-1:0] lo);
		return (v < lo) ? lo : v;
	endfunction

endpackage

// ===== src/bclp_if.sv =====
// Valid/ready channel interfaces: poll input, event output, configuration writes.
// Depends on bclp_pkg.
`timescale 1ns / 1ps

interface bclp_poll_if;
	logic                       valid;
	logic                       ready;
	logic                       pin_level;
	logic [bclp_pkg::TIME_W-1:0] time_ms;

	modport source (output valid, output pin_level, output time_ms, input ready);
	modport sink   (input valid, input pin_level, input time_ms, output ready);
endinterface

interface bclp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic       pressed;

	modport source (output valid, output event_res, output pressed, input ready);
	modport sink   (input valid, input event_res, input pressed, output ready);
endinterface

interface bclp_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 index;
	logic [bclp_pkg::CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/bclp_core.sv =====
// Detector state, configuration registers and the per-poll update logic.
// Depends on bclp_pkg.
`timescale 1ns / 1ps

module bclp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bclp_pkg::cfg_wr_t           cfg_wr,
	input  logic                        step,
	input  logic                        pin_level,
	input  logic [bclp_pkg::TIME_W-1:0] time_ms,
	output bclp_pkg::event_t            event_res,
	output logic                        pressed
);
	import bclp_pkg::*;

	// Configuration
	logic             active_q;
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;
	logic [CFG_W-1:0] click_to_q;

	// Detector state
	logic               raw_q;
	logic [TIME_W-1:0]  change_q;
	logic               stable_q;
	logic [TIME_W-1:0]  press_q;
	logic [TIME_W-1:0]  release_q;
	logic [CLICK_W-1:0] clicks_q;
	logic               long_done_q;

	// Next-state values
	logic               raw_d;
	logic [TIME_W-1:0]  change_d;
	logic               stable_d;
	logic [TIME_W-1:0]  press_d;
	logic [TIME_W-1:0]  release_d;
	logic [CLICK_W-1:0] clicks_d;
	logic               long_done_d;
	event_t             ev_d;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			click_to_q   <= CLICK_TO_RST;
		end else if (cfg_wr.en) begin
			unique case (cfg_wr.idx)
				REG_ACTIVE_LEVEL:    active_q     <= cfg_wr.data[0];
				REG_DEBOUNCE_TIME:   debounce_q   <= at_least(cfg_wr.data, DEBOUNCE_MIN);
				REG_LONG_PRESS_TIME: long_press_q <= at_least(cfg_wr.data, LONG_PRESS_MIN);
				REG_CLICK_TIMEOUT:   click_to_q   <= at_least(cfg_wr.data, CLICK_TO_MIN);
				default: ;
			endcase
		end
	end

	// One poll: debounce, press/release tracking, long press, click timeout
	always_comb begin
		raw_d       = raw_q;
		change_d    = change_q;
		stable_d    = stable_q;
		press_d     = press_q;
		release_d   = release_q;
		clicks_d    = clicks_q;
		long_done_d = long_done_q;
		ev_d        = EV_NONE;

		if (pin_level != raw_q) begin
			// raw edge: restart the debounce timer only
			raw_d    = pin_level;
			change_d = time_ms;
		end else if ((time_ms - change_q) >= {{(TIME_W-CFG_W){1'b0}}, debounce_q}) begin
			if (pin_level != stable_q) begin
				stable_d = pin_level;
				if (pin_level == active_q) begin
					press_d     = time_ms;
					long_done_d = 1'b0;
				end else begin
					release_d = time_ms;
					if (!long_done_q && clicks_q != CLICKS_MAX)
						clicks_d = clicks_q + 8'd1;
				end
			end
			// long press fires once per press and kills the click sequence
			if (stable_d == active_q && !long_done_d &&
					(time_ms - press_d) >= {{(TIME_W-CFG_W){1'b0}}, long_press_q}) begin
				long_done_d = 1'b1;
				ev_d        = EV_LONG;
				clicks_d    = '0;
			end
			// click sequence closes; four or more clicks are dropped
			if (clicks_d != '0 &&
					(time_ms - release_d) >= {{(TIME_W-CFG_W){1'b0}}, click_to_q}) begin
				case (clicks_d)
					8'd1:    ev_d = EV_SINGLE;
					8'd2:    ev_d = EV_DOUBLE;
					8'd3:    ev_d = EV_TRIPLE;
					default: ;
				endcase
				clicks_d = '0;
			end
		end
	end

	assign event_res = ev_d;
	assign pressed   = (stable_d == active_q);

	// State update on each processed poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q       <= 1'b1;
			change_q    <= '0;
			stable_q    <= 1'b1;
			press_q     <= '0;
			release_q   <= '0;
			clicks_q    <= '0;
			long_done_q <= 1'b0;
		end else if (step) begin
			raw_q       <= raw_d;
			change_q    <= change_d;
			stable_q    <= stable_d;
			press_q     <= press_d;
			release_q   <= release_d;
			clicks_q    <= clicks_d;
			long_done_q <= long_done_d;
		end
	end

endmodule

// ===== src/button_click_longpress_detector.sv =====
// Top level of the button click / long-press detector: channel registers around bclp_core.
// Depends on bclp_pkg, bclp_if.sv and bclp_core.
`timescale 1ns / 1ps

// Usage:
//   poll   - input channel; each beat is one sample of the raw pin (pin_level) with
//            its millisecond timestamp (time_ms, wrapping).
//   result - output channel; exactly one beat per poll beat, in order, carrying
//            event_res (none, long press, single, double, triple click) and the
//            debounced pressed flag after that poll.
//   cfg    - register writes: index 0 active level, 1 debounce time, 2 long-press
//            time, 3 click timeout. Always ready; write only while no poll is in flight.
// Path: a poll beat is registered in the input register, evaluated against the
// detector state once the result register is free or draining, and lands in the
// result register, from which its result is offered.
// Throughput is one poll per cycle while the receiver keeps ready high; the state
// update loop in bclp_core sets that figure.
// Stall: when the receiver holds ready low the result register holds, one more poll
// waits in the input register, and poll.ready falls until the result is taken.
// Reset (arst_n low) clears both registers, restores the default configuration and
// puts the detector in the released, idle-high state with no clicks counted.

module button_click_longpress_detector (
	input logic           clk,
	input logic           arst_n,
	bclp_poll_if.sink     poll,
	bclp_result_if.source result,
	bclp_cfg_if.sink      cfg
);
	import bclp_pkg::*;

	// Input register
	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] time_s1;

	// Result register
	logic       res_valid_q;
	event_t     event_q;
	logic       pressed_q;

	logic    advance;
	cfg_wr_t cfg_wr;
	event_t  core_event;
	logic    core_pressed;

	// Evaluate the registered poll when the result register is free or draining
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	assign cfg.ready  = 1'b1;
	assign cfg_wr.en   = cfg.valid;
	assign cfg_wr.idx  = cfg_reg_t'(cfg.index);
	assign cfg_wr.data = cfg.data;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			pin_s1  <= poll.pin_level;
			time_s1 <= poll.time_ms;
		end
	end

	bclp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.step      (advance),
		.pin_level (pin_s1),
		.time_ms   (time_s1),
		.event_res (core_event),
		.pressed   (core_pressed)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || result.ready) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= core_event;
			pressed_q <= core_pressed;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.event_res = event_q;
	assign result.pressed   = pressed_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for button_click_longpress_detector: directed and random polls,
// each result checked against an in-bench model of the debounce and click logic.
// Depends on bclp_pkg, bclp_if.sv and the detector RTL.

module testbench;
	import bclp_pkg::*;

	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_STALL   = 80;    // receiver hold-off that backs up the poll channel
	localparam int MAX_REPORTS  = 100;

	typedef struct packed {
		event_t ev;
		logic   pressed;
	} poll_result_t;

	// Scoreboard: mirrors the detector state and holds the results still owed
	class click_scoreboard;
		logic        active_lvl;
		logic [15:0] deb_time;
		logic [15:0] long_ms;
		logic [15:0] click_tmo;
		logic        raw_prev;
		logic [31:0] change_at;
		logic        stable_lvl;
		logic [31:0] press_at;
		logic [31:0] release_at;
		logic [7:0]  clicks;
		logic        long_done;
		poll_result_t owed_q[$];
		int          errors;
		int          polls;
		int          results;
		int          ev_count[5];

		function new();
			active_lvl  = 1'b0;
			deb_time    = DEBOUNCE_RST;
			long_ms     = LONG_PRESS_RST;
			click_tmo   = CLICK_TO_RST;
			raw_prev    = 1'b1;
			change_at   = '0;
			stable_lvl  = 1'b1;
			press_at    = '0;
			release_at  = '0;
			clicks      = '0;
			long_done   = 1'b0;
			errors      = 0;
			polls       = 0;
			results     = 0;
			foreach (ev_count[i]) ev_count[i] = 0;
		endfunction

		// Register write; timing values below their minimum are raised to it
		function void write_reg(cfg_reg_t idx, logic [15:0] d);
			case (idx)
				REG_ACTIVE_LEVEL:    active_lvl  = d[0];
				REG_DEBOUNCE_TIME:   deb_time    = (d < DEBOUNCE_MIN) ? DEBOUNCE_MIN : d;
				REG_LONG_PRESS_TIME: long_ms     = (d < LONG_PRESS_MIN) ? LONG_PRESS_MIN : d;
				REG_CLICK_TIMEOUT:   click_tmo   = (d < CLICK_TO_MIN) ? CLICK_TO_MIN : d;
				default: ;
			endcase
		endfunction

		// Accepted poll: advance the mirrored state and queue the result it causes
		function void note_poll(logic pin, logic [31:0] now);
			poll_result_t r;
			logic [31:0]  since_change;
			logic [31:0]  since_press;
			logic [31:0]  since_release;
			r.ev = EV_NONE;
			since_change = now - change_at;
			if (pin != raw_prev) begin
				// raw change only restarts the debounce timer
				raw_prev  = pin;
				change_at = now;
			end else if (since_change >= {16'd0, deb_time}) begin
				if (pin != stable_lvl) begin
					stable_lvl = pin;
					if (stable_lvl == active_lvl) begin
						press_at  = now;
						long_done = 1'b0;
					end else begin
						release_at = now;
						if (!long_done && clicks < CLICKS_MAX)
							clicks = clicks + 8'd1;
					end
				end
				since_press   = now - press_at;
				since_release = now - release_at;
				if (stable_lvl == active_lvl && !long_done &&
						since_press >= {16'd0, long_ms}) begin
					long_done = 1'b1;
					r.ev      = EV_LONG;
					clicks    = '0;
				end
				if (clicks != 0 && since_release >= {16'd0, click_tmo}) begin
					// four or more clicks close silently
					case (clicks)
						8'd1: r.ev = EV_SINGLE;
						8'd2: r.ev = EV_DOUBLE;
						8'd3: r.ev = EV_TRIPLE;
						default: ;
					endcase
					clicks = '0;
				end
			end
			r.pressed = (stable_lvl == active_lvl);
			owed_q.push_back(r);
			polls++;
			ev_count[int'(r.ev)]++;
		endfunction

		// Result beat: compare field by field with the oldest owed result
		function void check_result(logic [2:0] ev, logic pressed);
			poll_result_t exp_r;
			results++;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual event_res %0d pressed %0b",
						$time, ev, pressed);
				return;
			end
			exp_r = owed_q.pop_front();
			if (ev !== exp_r.ev) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: event_res mismatch, expected %0d (%s), actual %0d",
						$time, exp_r.ev, exp_r.ev.name(), ev);
			end
			if (pressed !== exp_r.pressed) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: pressed mismatch, expected %0b, actual %0b",
						$time, exp_r.pressed, pressed);
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bclp_poll_if   poll_ch();
	bclp_result_if res_ch();
	bclp_cfg_if    cfg_ch();

	button_click_longpress_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	click_scoreboard sb = new();

	bit          tx_calm;         // sender offers back to back
	bit          rx_calm;         // receiver never stalls
	bit          long_hold_req;   // ask the receiver for one long hold-off
	logic [31:0] cursor;          // running poll timestamp
	int unsigned step_max;        // step bound between polls; long holds may step further
	int          settings;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("[button_click_longpress_detector] ERROR");
		$finish;
	end

	// Poll beat: random gap, then hold valid until accepted
	task automatic send_poll(logic pin, logic [31:0] t);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			poll_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll_ch.valid     <= 1'b1;
		poll_ch.pin_level <= pin;
		poll_ch.time_ms   <= t;
		do @(posedge clk); while (!poll_ch.ready);
		sb.note_poll(pin, t);
	endtask

	task automatic tick_poll(logic pin, int unsigned dt);
		cursor = cursor + dt;
		send_poll(pin, cursor);
	endtask

	// Stop offering polls and wait until every owed result has arrived
	task automatic wait_drain();
		@(negedge clk);
		poll_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// New register setting, written only while the block is idle
	task automatic set_config(logic a, logic [15:0] d, logic [15:0] l, logic [15:0] t);
		int unsigned m;
		wait_drain();
		write_reg(REG_ACTIVE_LEVEL, {15'd0, a});
		write_reg(REG_DEBOUNCE_TIME, d);
		write_reg(REG_LONG_PRESS_TIME, l);
		write_reg(REG_CLICK_TIMEOUT, t);
		m = ((sb.long_ms < sb.click_tmo) ? sb.long_ms : sb.click_tmo) / 10;
		step_max = (sb.deb_time > m) ? sb.deb_time : m;
		settings++;
	endtask

	// A few raw toggles shorter than the debounce time, ending at lvl
	task automatic bounce_to(logic lvl);
		int unsigned n;
		n = $urandom_range(0, 3);
		for (int unsigned i = 0; i <= 2 * n; i++)
			tick_poll((i % 2 == 0) ? lvl : !lvl, $urandom_range(0, sb.deb_time - 1));
	endtask

	// Steady level for at least span ms
	task automatic hold_for(logic lvl, int unsigned span);
		int unsigned elapsed;
		int unsigned dt;
		int unsigned hi;
		elapsed = 0;
		// long spans take coarser steps so one hold stays a few dozen polls
		hi = (span / 8 > step_max) ? span / 8 : step_max;
		do begin
			dt = $urandom_range(1, hi);
			tick_poll(lvl, dt);
			elapsed += dt;
		end while (elapsed < span);
	endtask

	// n short presses, releases inside the click timeout, the last one left to expire
	task automatic click_burst(int unsigned n);
		logic        act;
		int unsigned deb;
		act = sb.active_lvl;
		deb = sb.deb_time;
		for (int unsigned i = 0; i < n; i++) begin
			bounce_to(act);
			hold_for(act, deb + $urandom_range(0, sb.long_ms / 2));
			bounce_to(!act);
			if (i == n - 1)
				hold_for(!act, deb + sb.click_tmo + $urandom_range(0, sb.click_tmo / 2));
			else
				hold_for(!act, deb + $urandom_range(0, sb.click_tmo / 3));
		end
	endtask

	task automatic long_hold();
		logic        act;
		int unsigned deb;
		act = sb.active_lvl;
		deb = sb.deb_time;
		bounce_to(act);
		hold_for(act, deb + sb.long_ms + $urandom_range(0, sb.long_ms / 2));
		bounce_to(!act);
		hold_for(!act, deb + sb.click_tmo + $urandom_range(0, sb.click_tmo));
	endtask

	// Mostly well-formed press patterns, the rest noise and broken presses
	task automatic random_polls(int unsigned n);
		int unsigned target;
		int unsigned pick;
		target = sb.polls + n;
		while (sb.polls < target) begin
			if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3, 4: click_burst($urandom_range(1, 5));
				5, 6: long_hold();
				7: begin
					cursor = $urandom();
					send_poll(1'($urandom_range(0, 1)), cursor);
				end
				8: begin
					if ($urandom_range(0, 1)) cursor = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max);
					tick_poll(1'($urandom_range(0, 1)), $urandom_range(0, step_max));
				end
				default: begin
					// press that never settles
					bounce_to(sb.active_lvl);
					tick_poll(!sb.active_lvl, $urandom_range(0, sb.deb_time - 1));
				end
			endcase
		end
	endtask

	// Result receiver: random stalls, calm stretches, one long hold-off on request
	initial begin
		int unsigned stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 10);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_STALL;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			sb.check_result(res_ch.event_res, res_ch.pressed);
		end
	end

	// Stimulus
	initial begin
		poll_ch.valid     = 1'b0;
		poll_ch.pin_level = 1'b1;
		poll_ch.time_ms   = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_ACTIVE_LEVEL;
		cfg_ch.data       = '0;
		tx_calm           = 1'b0;
		rx_calm           = 1'b0;
		long_hold_req     = 1'b0;
		cursor            = '0;
		step_max          = 30;
		settings          = 1;
		arst_n            = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings: bounce, single click
		send_poll(1'b1, 32'd0);
		send_poll(1'b0, 32'd5);
		send_poll(1'b0, 32'd10);
		send_poll(1'b0, 32'd15);
		send_poll(1'b1, 32'd20);
		send_poll(1'b0, 32'd22);
		send_poll(1'b0, 32'd40);
		send_poll(1'b1, 32'd50);
		send_poll(1'b1, 32'd60);
		send_poll(1'b1, 32'd400);
		// double click
		send_poll(1'b0, 32'd410);
		send_poll(1'b0, 32'd420);
		send_poll(1'b1, 32'd450);
		send_poll(1'b1, 32'd460);
		send_poll(1'b0, 32'd470);
		send_poll(1'b0, 32'd480);
		send_poll(1'b1, 32'd500);
		send_poll(1'b1, 32'd510);
		send_poll(1'b1, 32'd900);
		// long press, then a release that is not a click, then the top timestamp
		send_poll(1'b0, 32'd1000);
		send_poll(1'b0, 32'd1010);
		send_poll(1'b0, 32'd2010);
		send_poll(1'b1, 32'd2020);
		send_poll(1'b1, 32'd2030);
		send_poll(1'b1, 32'hFFFF_FFFF);
		cursor = 32'hFFFF_FFFF;

		// Random, reset settings, crossing the timestamp wrap
		random_polls(220);

		// Writes below every minimum
		set_config(1'b1, 16'd0, 16'd5, 16'd99);
		random_polls(220);

		set_config(1'b0, 16'd1, 16'd100, 16'd100);
		random_polls(200);

		// Receiver holds off while the sender offers back to back
		set_config(1'b1, 16'd20, 16'd400, 16'd250);
		tx_calm       = 1'b1;
		long_hold_req = 1'b1;
		click_burst(3);
		tx_calm = 1'b0;
		random_polls(200);

		// Largest timing values
		set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_polls(100);

		// Random setting, sender pauses midway until the block is empty
		set_config(1'b1, 16'($urandom_range(2, 50)), 16'($urandom_range(100, 2000)),
			16'($urandom_range(100, 1000)));
		random_polls(120);
		wait_drain();
		random_polls(120);

		set_config(1'b0, 16'd3, 16'hFFFF, 16'd100);
		random_polls(100);

		wait_drain();
		if (sb.pending() != 0) sb.errors++;

		$display("Checked %0d results for %0d polls across %0d register settings.",
			sb.results, sb.polls, settings);
		$display("Events seen: %0d long, %0d single, %0d double, %0d triple; %0d failures.",
			sb.ev_count[int'(EV_LONG)], sb.ev_count[int'(EV_SINGLE)],
			sb.ev_count[int'(EV_DOUBLE)], sb.ev_count[int'(EV_TRIPLE)], sb.errors);
		if (sb.errors == 0) begin
			$display("[button_click_longpress_detector] OK");
		end else begin
			$display("[button_click_longpress_detector] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/bclp_pkg.sv
src/bclp_if.sv
src/bclp_core.sv
src/button_click_longpress_detector.sv
tb/testbench.sv
